/* design/rlpe_pkg.sv */
// shared types, register codes and the brightness table of the rgb led pwm bit encoder
`timescale 1ns / 1ps

package rlpe_pkg;

  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned SLOTS_MAX      = 64;
  localparam int unsigned TAN_W          = 17;
  localparam int unsigned Q_SHIFT        = 16;

  localparam logic [TAN_W-1:0] TAN_ONE = 17'd65536;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_BRIGHTNESS        = 3'd0,
    CFG_BRIGHTNESS_ENABLE = 3'd1,
    CFG_HIGH_DUTY         = 3'd2,
    CFG_LOW_DUTY          = 3'd3,
    CFG_RESET_SLOTS       = 3'd4
  } rlpe_cfg_idx_t;

  localparam logic [5:0] BRIGHT_RST      = 6'd45;
  localparam logic       BRIGHT_EN_RST   = 1'b1;
  localparam logic [7:0] HIGH_DUTY_RST   = 8'd75;
  localparam logic [7:0] LOW_DUTY_RST    = 8'd38;
  localparam logic [6:0] RESET_SLOTS_RST = 7'd50;

  typedef struct packed {
    logic [5:0] brightness;
    logic       brightness_enable;
    logic [7:0] high_duty;
    logic [7:0] low_duty;
    logic [6:0] reset_slots;
  } rlpe_cfg_t;

  // one packed pixel or a frame end on its way to the serializer
  typedef struct packed {
    logic        frame_end;
    logic [23:0] word;
  } rlpe_item_t;

  // tan(b degrees) in unsigned q1.16, angles above 45 saturate to full scale
  function automatic logic [TAN_W-1:0] tan_q16(input logic [5:0] b);
    logic [TAN_W-1:0] t;
    unique case (b)
      6'd0:  t = 17'd0;
      6'd1:  t = 17'd1144;
      6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;
      6'd4:  t = 17'd4583;
      6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;
      6'd7:  t = 17'd8047;
      6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380;
      6'd10: t = 17'd11556;
      6'd11: t = 17'd12739;
      6'd12: t = 17'd13930;
      6'd13: t = 17'd15130;
      6'd14: t = 17'd16340;
      6'd15: t = 17'd17560;
      6'd16: t = 17'd18792;
      6'd17: t = 17'd20036;
      6'd18: t = 17'd21294;
      6'd19: t = 17'd22566;
      6'd20: t = 17'd23853;
      6'd21: t = 17'd25157;
      6'd22: t = 17'd26478;
      6'd23: t = 17'd27818;
      6'd24: t = 17'd29179;
      6'd25: t = 17'd30560;
      6'd26: t = 17'd31964;
      6'd27: t = 17'd33392;
      6'd28: t = 17'd34846;
      6'd29: t = 17'd36327;
      6'd30: t = 17'd37837;
      6'd31: t = 17'd39378;
      6'd32: t = 17'd40951;
      6'd33: t = 17'd42560;
      6'd34: t = 17'd44205;
      6'd35: t = 17'd45889;
      6'd36: t = 17'd47615;
      6'd37: t = 17'd49385;
      6'd38: t = 17'd51202;
      6'd39: t = 17'd53070;
      6'd40: t = 17'd54991;
      6'd41: t = 17'd56970;
      6'd42: t = 17'd59009;
      6'd43: t = 17'd61113;
      6'd44: t = 17'd63287;
      default: t = TAN_ONE;
    endcase
    return t;
  endfunction

endpackage

/* design/rlpe_scaler.sv */
// three-stage brightness scaling pipeline: table lookup, multiply, pack
`timescale 1ns / 1ps

module rlpe_scaler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  rlpe_pkg::rlpe_cfg_t  cfg,
  output logic                 item_valid,
  output rlpe_pkg::rlpe_item_t item,
  input  logic                 item_take
);

  // stage 1: raw bytes and table factor
  logic                         s1_valid_r;
  logic                         s1_mode_r;
  logic [7:0]                   s1_red_r, s1_green_r, s1_blue_r;
  logic [rlpe_pkg::TAN_W-1:0]   s1_tan_r;
  // stage 2: scaled bytes
  logic                         s2_valid_r;
  logic                         s2_mode_r;
  logic [7:0]                   s2_red_r, s2_green_r, s2_blue_r;
  // stage 3: packed word
  logic                         s3_valid_r;
  rlpe_pkg::rlpe_item_t         s3_item_r;

  logic                         s1_free, s2_free, s3_free;
  logic [rlpe_pkg::TAN_W-1:0]   tan_sel;
  logic [24:0]                  prod_red, prod_green, prod_blue;

  assign s3_free  = !s3_valid_r || item_take;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  // a factor of one leaves the bytes raw
  assign tan_sel = cfg.brightness_enable ? rlpe_pkg::tan_q16(cfg.brightness)
                                         : rlpe_pkg::TAN_ONE;

  assign prod_red   = 25'(s1_red_r)   * 25'(s1_tan_r);
  assign prod_green = 25'(s1_green_r) * 25'(s1_tan_r);
  assign prod_blue  = 25'(s1_blue_r)  * 25'(s1_tan_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_take;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_free) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_mode_r  <= in_mode;
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_tan_r   <= tan_sel;
    end
    if (s2_free) begin
      s2_mode_r  <= s1_mode_r;
      s2_red_r   <= prod_red[rlpe_pkg::Q_SHIFT+7:rlpe_pkg::Q_SHIFT];
      s2_green_r <= prod_green[rlpe_pkg::Q_SHIFT+7:rlpe_pkg::Q_SHIFT];
      s2_blue_r  <= prod_blue[rlpe_pkg::Q_SHIFT+7:rlpe_pkg::Q_SHIFT];
    end
    if (s3_free) begin
      s3_item_r.frame_end <= s2_mode_r;
      s3_item_r.word      <= {s2_green_r, s2_red_r, s2_blue_r};
    end
  end

  assign item_valid = s3_valid_r;
  assign item       = s3_item_r;

  // a held item stays put until the serializer takes it
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !item_take) |=> (s3_valid_r && $stable(s3_item_r)))
    else $error("stage 3 item changed while waiting");

  // nothing enters while the front stage is stalled
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> s1_free)
    else $error("transaction taken while front stage stalled");

endmodule

/* design/rlpe_serializer.sv */
// turns packed pixels and frame ends into a stream of pwm duty words
`timescale 1ns / 1ps

module rlpe_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlpe_pkg::rlpe_cfg_t  cfg,
  input  logic                 item_valid,
  input  rlpe_pkg::rlpe_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  output logic [7:0]           out_duty,
  output logic                 out_last
);

  logic        ser_active_r;
  logic [6:0]  ser_cnt_r;
  logic [23:0] ser_word_r;
  logic        ser_frame_r;
  logic        out_valid_r;
  logic [7:0]  out_duty_r;
  logic        out_last_r;

  logic        ser_free;
  logic [6:0]  slots_clamped;
  logic [6:0]  load_cnt;

  assign ser_free  = !ser_active_r || (ser_cnt_r == 7'd1);
  assign item_take = item_valid && ser_free;

  assign slots_clamped = (cfg.reset_slots > 7'(rlpe_pkg::SLOTS_MAX))
                         ? 7'(rlpe_pkg::SLOTS_MAX) : cfg.reset_slots;
  assign load_cnt = item.frame_end ? slots_clamped : 7'(rlpe_pkg::BITS_PER_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= ser_active_r;
      if (item_take) begin
        // a frame end with zero slots leaves the serializer idle
        ser_active_r <= (load_cnt != 7'd0);
      end else if (ser_active_r) begin
        ser_active_r <= (ser_cnt_r != 7'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    // last flag only rides along with a word
    out_last_r <= ser_active_r && (ser_cnt_r == 7'd1);
    if (ser_active_r) begin
      out_duty_r <= ser_frame_r ? 8'd0 : (ser_word_r[23] ? cfg.high_duty : cfg.low_duty);
    end
    if (item_take) begin
      ser_cnt_r   <= load_cnt;
      ser_word_r  <= item.word;
      ser_frame_r <= item.frame_end;
    end else if (ser_active_r) begin
      ser_cnt_r  <= ser_cnt_r - 7'd1;
      ser_word_r <= {ser_word_r[22:0], 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_last  = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_active_r |-> (ser_cnt_r != 7'd0 && ser_cnt_r <= 7'(rlpe_pkg::SLOTS_MAX)))
    else $error("serializer count out of range while active");

  a_keeps_going: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_active_r && ser_cnt_r > 7'd1) |=> (ser_active_r && out_valid_r))
    else $error("serializer stopped before its last word");

  a_last_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_active_r && ser_cnt_r == 7'd1 && !item_take) |=> ##1 !out_valid_r)
    else $error("word emitted after last word with nothing loaded");

endmodule

/* design/rgb_led_pwm_bit_encoder.sv */
// top level of the rgb led pwm bit encoder: config registers, scaler and serializer
`timescale 1ns / 1ps
// path: an accepted transaction passes scaler stages 1 to 3 and, when the serializer is
//   free, its load and the output register; its duty words then follow one per cycle
// throughput: a pixel gives 24 duty words, a frame end min(reset_slots, 64) zero words;
//   the one-word-per-cycle serializer sets the rate, the 3-stage scaler keeps it fed
// reset: synchronous active-low rst_n clears all valid bits and loads the register
//   reset values; results are strobed for one cycle and the receiver cannot stall

module rgb_led_pwm_bit_encoder (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  // duty word stream
  output logic       out_valid,
  output logic [7:0] out_duty,
  output logic       out_last,
  // configuration write port
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  rlpe_pkg::rlpe_cfg_t  cfg_r;
  rlpe_pkg::rlpe_item_t item;
  logic                 item_valid;
  logic                 item_take;
  logic                 in_ready;
  logic                 in_take;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness        <= rlpe_pkg::BRIGHT_RST;
      cfg_r.brightness_enable <= rlpe_pkg::BRIGHT_EN_RST;
      cfg_r.high_duty         <= rlpe_pkg::HIGH_DUTY_RST;
      cfg_r.low_duty          <= rlpe_pkg::LOW_DUTY_RST;
      cfg_r.reset_slots       <= rlpe_pkg::RESET_SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlpe_pkg::CFG_BRIGHTNESS:        cfg_r.brightness        <= cfg_data[5:0];
        rlpe_pkg::CFG_BRIGHTNESS_ENABLE: cfg_r.brightness_enable <= cfg_data[0];
        rlpe_pkg::CFG_HIGH_DUTY:         cfg_r.high_duty         <= cfg_data;
        rlpe_pkg::CFG_LOW_DUTY:          cfg_r.low_duty          <= cfg_data;
        rlpe_pkg::CFG_RESET_SLOTS:       cfg_r.reset_slots       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // busy only when the front stage of the scaler cannot move
  assign busy    = !in_ready;
  assign in_take = start && in_ready;

  rlpe_scaler u_scaler (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rlpe_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_duty   (out_duty),
    .out_last   (out_last)
  );

  // a last flag only comes with a duty word; every item handed over but an empty frame end gives words
  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last flag without a duty word");

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> item_valid)
    else $error("serializer took a transaction that was not there");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("block not idle after reset");

endmodule

/* tb/rgb_led_pwm_bit_encoder_test.sv */
// self-checking testbench for the rgb led pwm bit encoder: directed and random transactions
`timescale 1ns / 1ps

module rgb_led_pwm_bit_encoder_test;

  // cycles with no accepted transaction on either side before the run is abandoned
  localparam int unsigned IDLE_LIMIT   = 1000;
  // quiet cycles after the last expected duty word, covers pipeline plus zero-slot frame ends
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 86;
  localparam int unsigned BRIGHT_FULL  = 45;
  // register indexes past the last defined register, writes there must change nothing
  localparam logic [2:0]  CFG_FIRST_SPARE = 3'd5;
  localparam logic        MODE_PIXEL      = 1'b0;
  localparam logic        MODE_FRAME_END  = 1'b1;

  typedef struct {
    logic [7:0] duty;
    logic       last;
  } duty_word_t;

  // tan(b degrees) in unsigned q1.16 for b = 0..45
  int unsigned tan_lut [0:45] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294,
    22566, 23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392,
    34846, 36327, 37837, 39378, 40951, 42560, 44205, 45889, 47615,
    49385, 51202, 53070, 54991, 56970, 59009, 61113, 63287, 65536
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  logic       in_mode   = 1'b0;
  logic [7:0] in_red    = 8'd0;
  logic [7:0] in_green  = 8'd0;
  logic [7:0] in_blue   = 8'd0;
  logic       out_valid;
  logic [7:0] out_duty;
  logic       out_last;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data  = 8'd0;

  // local copy of the register file, starts at the reset values
  logic [5:0] cur_brightness   = rlpe_pkg::BRIGHT_RST;
  logic       cur_bright_en    = rlpe_pkg::BRIGHT_EN_RST;
  logic [7:0] cur_high_duty    = rlpe_pkg::HIGH_DUTY_RST;
  logic [7:0] cur_low_duty     = rlpe_pkg::LOW_DUTY_RST;
  logic [6:0] cur_reset_slots  = rlpe_pkg::RESET_SLOTS_RST;

  // duty words still owed by the block, oldest first
  duty_word_t  duty_words_expected [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  rgb_led_pwm_bit_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_mode   (in_mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_duty  (out_duty),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // brightness scaling of one colour byte, angles above 45 act as full scale
  function automatic logic [7:0] scale_color(input logic [7:0] c);
    int unsigned angle;
    angle = (cur_brightness > BRIGHT_FULL) ? BRIGHT_FULL : cur_brightness;
    return 8'((c * tan_lut[angle]) >> rlpe_pkg::Q_SHIFT);
  endfunction

  // queue the duty words one transaction should produce
  function automatic void predict_duty_words(input logic mode, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    logic [23:0] grb;
    int unsigned slots;
    duty_word_t  w;
    if (mode == MODE_FRAME_END) begin
      // frame end: zero words, count clipped to 64, colours ignored
      slots = (cur_reset_slots > rlpe_pkg::SLOTS_MAX) ? rlpe_pkg::SLOTS_MAX
                                                      : cur_reset_slots;
      for (int k = 0; k < slots; k++) begin
        w.duty = 8'd0;
        w.last = (k == slots - 1);
        duty_words_expected.push_back(w);
      end
    end else begin
      if (cur_bright_en) begin
        grb = {scale_color(g), scale_color(r), scale_color(b)};
      end else begin
        grb = {g, r, b};
      end
      // msb first, one duty word per bit
      for (int i = rlpe_pkg::BITS_PER_PIXEL - 1; i >= 0; i--) begin
        w.duty = grb[i] ? cur_high_duty : cur_low_duty;
        w.last = (i == 0);
        duty_words_expected.push_back(w);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking and watchdog, sampled mid-cycle so no edge ordering matters
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : check_duty_words
    duty_word_t want;
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        if (duty_words_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected duty word: valid=%b duty=%0d last=%b",
                     out_valid, out_duty, out_last);
        end else begin
          want = duty_words_expected.pop_front();
          if (out_valid !== 1'b1 || out_duty !== want.duty || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("duty word mismatch: expected duty=%0d last=%b, got valid=%b duty=%0d last=%b",
                       want.duty, want.last, out_valid, out_duty, out_last);
          end
        end
      end
    end
    // anything accepted on either side this cycle restarts the count
    if (out_valid === 1'b1 || (start && busy === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all entered and left at a rising edge
  // ---------------------------------------------------------------------------

  // present one transaction and hold it until the block takes it; start stays high
  task automatic send_item(input logic mode, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    start    <= 1'b1;
    in_mode  <= mode;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    // busy was low mid-cycle, so the coming edge accepts the transaction
    @(posedge clk);
    predict_duty_words(mode, r, g, b);
  endtask

  // sender gap, inputs carry noise while start is low
  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      start    <= 1'b0;
      in_mode  <= 1'($urandom);
      in_red   <= 8'($urandom);
      in_green <= 8'($urandom);
      in_blue  <= 8'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait for every owed duty word, then let zero-word frame ends drain
  task automatic settle();
    start <= 1'b0;
    while (duty_words_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, leaves cfg_we high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rlpe_pkg::CFG_BRIGHTNESS:        cur_brightness  = data[5:0];
      rlpe_pkg::CFG_BRIGHTNESS_ENABLE: cur_bright_en   = data[0];
      rlpe_pkg::CFG_HIGH_DUTY:         cur_high_duty   = data;
      rlpe_pkg::CFG_LOW_DUTY:          cur_low_duty    = data;
      rlpe_pkg::CFG_RESET_SLOTS:       cur_reset_slots = data[6:0];
      default: ;
    endcase
  endtask

  // full register set, only called while the block is idle
  task automatic apply_config(input logic [7:0] bright, input logic [7:0] bright_en,
                              input logic [7:0] high, input logic [7:0] low,
                              input logic [7:0] slots);
    write_reg(rlpe_pkg::CFG_BRIGHTNESS, bright);
    write_reg(rlpe_pkg::CFG_BRIGHTNESS_ENABLE, bright_en);
    write_reg(rlpe_pkg::CFG_HIGH_DUTY, high);
    write_reg(rlpe_pkg::CFG_LOW_DUTY, low);
    write_reg(rlpe_pkg::CFG_RESET_SLOTS, slots);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // colour byte with extra weight on the extremes
  function automatic logic [7:0] random_color();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: full brightness, so bytes pass unchanged, 50 reset slots
  task automatic test_reset_values();
    send_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(MODE_PIXEL, 8'hAA, 8'h55, 8'h81);
    // colours on a frame end are don't-care
    send_item(MODE_FRAME_END, 8'hFF, 8'hFF, 8'hFF);
    settle();
  endtask

  // brightness from off to past full scale, top angle reached through masked upper bits
  task automatic test_brightness_scaling();
    logic [7:0] angle_data [0:6] = '{8'd0, 8'd1, 8'd30, 8'd44, 8'd45, 8'd46, 8'hFF};
    for (int k = 0; k < 7; k++) begin
      apply_config(angle_data[k], 8'd1, rlpe_pkg::HIGH_DUTY_RST, rlpe_pkg::LOW_DUTY_RST,
                   8'(rlpe_pkg::RESET_SLOTS_RST));
      send_item(MODE_PIXEL, 8'hFF, 8'h80, 8'h7F);
      settle();
    end
  endtask

  // scaling off, enable bit taken from bit 0 only
  task automatic test_raw_colors();
    apply_config(8'd20, 8'hFE, rlpe_pkg::HIGH_DUTY_RST, rlpe_pkg::LOW_DUTY_RST,
                 8'(rlpe_pkg::RESET_SLOTS_RST));
    send_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(MODE_PIXEL, 8'h01, 8'h80, 8'h7F);
    settle();
  endtask

  // duty words at both ends of their range and equal
  task automatic test_duty_extremes();
    apply_config(8'd45, 8'd0, 8'h00, 8'hFF, 8'(rlpe_pkg::RESET_SLOTS_RST));
    send_item(MODE_PIXEL, 8'hA5, 8'h5A, 8'hC3);
    settle();
    apply_config(8'd45, 8'd0, 8'hFF, 8'h00, 8'(rlpe_pkg::RESET_SLOTS_RST));
    send_item(MODE_PIXEL, 8'hA5, 8'h5A, 8'hC3);
    settle();
    apply_config(8'd45, 8'd0, 8'h5A, 8'h5A, 8'(rlpe_pkg::RESET_SLOTS_RST));
    send_item(MODE_PIXEL, 8'hA5, 8'h5A, 8'hC3);
    settle();
  endtask

  // frame end lengths: none, one, full, clipped just above and far above
  task automatic test_reset_slot_counts();
    logic [7:0] slot_data [0:4] = '{8'd0, 8'd1, 8'd64, 8'd65, 8'hFF};
    for (int k = 0; k < 5; k++) begin
      apply_config(8'd33, 8'd1, 8'd90, 8'd20, slot_data[k]);
      send_item(MODE_FRAME_END, 8'($urandom), 8'($urandom), 8'($urandom));
      // a pixel right behind a frame end that produces nothing
      if (k == 0) send_item(MODE_PIXEL, 8'h12, 8'hE7, 8'h3C);
      settle();
    end
  endtask

  // writes past the last register must leave every setting alone
  task automatic test_spare_register_index();
    apply_config(8'd12, 8'd1, 8'd200, 8'd3, 8'd3);
    for (int i = CFG_FIRST_SPARE; i < 2 ** $bits(cfg_index); i++)
      write_reg(3'(i), 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    send_item(MODE_PIXEL, 8'hF0, 8'h0F, 8'h99);
    send_item(MODE_FRAME_END, 8'h00, 8'h00, 8'h00);
    settle();
  endtask

  // random phases: fresh settings each phase, bursts of transactions with random gaps
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned burst_left;
    logic [7:0]  slots;
    bit          steady;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // mostly short frame ends, now and then long or clipped ones
      slots = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), slots);
      phase_len  = $urandom_range(8, 24);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(MODE_FRAME_END, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(MODE_PIXEL, random_color(), random_color(), random_color());
        end
        sent++;
        // steady phases keep start high back to back
        if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            pause($urandom_range(1, 12));
            burst_left = $urandom_range(1, 8);
          end
        end
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // synchronous reset held low at the start, then released
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_brightness_scaling();
    test_raw_colors();
    test_duty_extremes();
    test_reset_slot_counts();
    test_spare_register_index();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
